// ----- rtl/ps2mpt_pkg.sv -----
// Package for the PS/2 mouse packet tracker: types, register indexes and decode helpers.
package ps2mpt_pkg;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned DeltaW   = 13;
    localparam int unsigned PosW     = 7;
    localparam int unsigned ThrW     = 7;
    localparam int unsigned GainW    = 4;
    localparam int unsigned WheelW   = 8;
    localparam int unsigned OutDataW = 56;

    typedef logic [CfgIdxW-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_FOUR_BYTE = 3'd0;
    localparam t_cfg_idx CFG_ACCEL_THR = 3'd1;
    localparam t_cfg_idx CFG_ACCEL_GAIN = 3'd2;
    localparam t_cfg_idx CFG_X_LIMIT = 3'd3;
    localparam t_cfg_idx CFG_Y_LIMIT = 3'd4;

    localparam logic [ThrW-1:0]  RST_ACCEL_THR  = 7'd5;
    localparam logic [GainW-1:0] RST_ACCEL_GAIN = 4'd4;
    localparam logic [PosW-1:0]  RST_X_LIMIT    = 7'd80;
    localparam logic [PosW-1:0]  RST_Y_LIMIT    = 7'd24;

    typedef struct packed {
        logic [WheelW-1:0]        wheel_count;
        logic [PosW-1:0]          cursor_y;
        logic [PosW-1:0]          cursor_x;
        logic signed [DeltaW-1:0] move_y;
        logic signed [DeltaW-1:0] move_x;
        logic                     button_five;
        logic                     button_four;
        logic                     middle_button;
        logic                     right_button;
        logic                     left_button;
    } t_result;

    // Multiplies a delta by the gain when its magnitude is above the threshold.
    function automatic logic signed [DeltaW-1:0] accel_delta(
        input logic signed [9:0] d,
        input logic [ThrW-1:0]   thr,
        input logic [GainW-1:0]  gain
    );
        logic signed [9:0]  mag;
        logic signed [14:0] prod;
        mag  = d[9] ? -d : d;
        prod = d * $signed({1'b0, gain});
        if (mag > $signed({3'b000, thr})) begin
            accel_delta = prod[DeltaW-1:0];
        end else begin
            accel_delta = {{(DeltaW-10){d[9]}}, d};
        end
    endfunction

    // Adds a delta to a position at full width, then clamps to 1..limit.
    function automatic logic [PosW-1:0] clamp_pos(
        input logic [PosW-1:0]          pos,
        input logic signed [DeltaW-1:0] d,
        input logic [PosW-1:0]          lim
    );
        logic signed [DeltaW:0] sum;
        logic signed [DeltaW:0] lim_s;
        lim_s = $signed({{(DeltaW+1-PosW){1'b0}}, lim});
        sum   = $signed({{(DeltaW+1-PosW){1'b0}}, pos}) + {d[DeltaW-1], d};
        if (sum > lim_s) begin
            sum = lim_s;
        end
        if (sum < $signed({{DeltaW{1'b0}}, 1'b1})) begin
            sum = $signed({{DeltaW{1'b0}}, 1'b1});
        end
        clamp_pos = sum[PosW-1:0];
    endfunction

endpackage

// ----- rtl/ps2_mouse_packet_tracker_core.sv -----
// PS/2 mouse packet tracker: packet assembly, delta decode, acceleration and cursor tracking.
//
// Usage: raw mouse bytes enter on the s_axis request channel, one byte per request.
// Three bytes form a packet, or four when the four-byte mode register is set.
// Only the request carrying the final byte of a packet yields a result on the
// m_axis channel; all other bytes are absorbed silently.
// Each byte is first captured in an input register; the decode, acceleration,
// cursor clamp and wheel update are shallow logic that load the result register
// as a finishing byte leaves the input register. One byte per cycle is accepted
// in steady state, as long as no finishing byte is held up by a stalled receiver.
// When the receiver stalls, the result register holds its request; the input
// register keeps absorbing bytes that do not finish a packet, and stalls only
// when a finishing byte would need the still occupied result register.
// Synchronous reset clears the byte position, cursor (0,0), wheel count and
// both valid flags, and restores the register defaults (three-byte mode,
// threshold 5, gain 4, limits 80 by 24). Registers are written through the
// plain write port and must only change while the block is idle.
module ps2_mouse_packet_tracker_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  ps2mpt_pkg::t_cfg_idx               i_cfg_index,
    input  logic [6:0]                         i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: data_byte[7:0]
    input  logic [7:0]                         s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata from bit 0 up: left_button, right_button, middle_button, button_four,
    // button_five, move_x[12:0], move_y[12:0], cursor_x[6:0], cursor_y[6:0],
    // wheel_count[7:0], zero fill [55:53]
    output logic [ps2mpt_pkg::OutDataW-1:0]    m_axis_tdata
);
    import ps2mpt_pkg::*;

    // Configuration registers.
    logic             r_four_byte;
    logic [ThrW-1:0]  r_accel_thr;
    logic [GainW-1:0] r_accel_gain;
    logic [PosW-1:0]  r_x_limit;
    logic [PosW-1:0]  r_y_limit;

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Packet state.
    logic [1:0]        r_byte_index;
    logic [1:0]        n_byte_index;
    logic [7:0]        r_pkt_b0;
    logic [7:0]        r_pkt_b1;
    logic [7:0]        r_pkt_b2;
    logic [PosW-1:0]   r_cursor_col;
    logic [PosW-1:0]   r_cursor_row;
    logic [WheelW-1:0] r_wheel_total;

    // Result register.
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;

    logic       last_is_final;
    logic       advance;
    logic       load_out;
    logic [7:0] b2;
    logic [7:0] b3;
    logic signed [8:0] dx_raw;
    logic signed [8:0] dy_raw;
    logic signed [9:0] dx_ext;
    logic signed [9:0] dy_neg;
    logic signed [DeltaW-1:0] dx_acc;
    logic signed [DeltaW-1:0] dy_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four_byte  <= 1'b0;
            r_accel_thr  <= RST_ACCEL_THR;
            r_accel_gain <= RST_ACCEL_GAIN;
            r_x_limit    <= RST_X_LIMIT;
            r_y_limit    <= RST_Y_LIMIT;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_FOUR_BYTE:  r_four_byte  <= i_cfg_wdata[0];
                CFG_ACCEL_THR:  r_accel_thr  <= i_cfg_wdata;
                CFG_ACCEL_GAIN: r_accel_gain <= i_cfg_wdata[GainW-1:0];
                CFG_X_LIMIT:    r_x_limit    <= i_cfg_wdata;
                CFG_Y_LIMIT:    r_y_limit    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // A packet completes once the position reaches the final slot of the
    // current mode or lies past it, as after a switch back to three bytes.
    assign last_is_final = (r_byte_index >= (r_four_byte ? 2'd3 : 2'd2));

    // The held byte moves on unless it finishes a packet while the result
    // register is still full and not being taken.
    assign advance  = r_in_valid && (!last_is_final || !r_out_valid || m_axis_tready);
    assign load_out = advance && last_is_final;
    assign s_axis_tready = !r_in_valid || advance;

    always_comb begin
        b2 = r_four_byte ? r_pkt_b2 : r_in_byte;
        b3 = r_four_byte ? r_in_byte : 8'h00;

        dx_raw = $signed({r_pkt_b0[4], r_pkt_b1});
        dy_raw = $signed({r_pkt_b0[5], b2});
        dx_ext = {dx_raw[8], dx_raw};
        dy_neg = -$signed({dy_raw[8], dy_raw});

        dx_acc = accel_delta(dx_ext, r_accel_thr, r_accel_gain);
        dy_acc = accel_delta(dy_neg, r_accel_thr, r_accel_gain);

        n_out.left_button   = r_pkt_b0[0];
        n_out.right_button  = r_pkt_b0[1];
        n_out.middle_button = r_pkt_b0[2];
        n_out.button_four   = b3[4];
        n_out.button_five   = b3[5];
        n_out.move_x        = dx_acc;
        n_out.move_y        = dy_acc;
        n_out.cursor_x      = clamp_pos(r_cursor_col, dx_acc, r_x_limit);
        n_out.cursor_y      = clamp_pos(r_cursor_row, dy_acc, r_y_limit);
        n_out.wheel_count   = r_wheel_total + {{(WheelW-4){b3[3]}}, b3[3:0]};

        n_byte_index = last_is_final ? 2'd0 : r_byte_index + 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_byte_index  <= 2'd0;
            r_cursor_col  <= '0;
            r_cursor_row  <= '0;
            r_wheel_total <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_byte_index <= n_byte_index;
            end
            if (load_out) begin
                r_cursor_col  <= n_out.cursor_x;
                r_cursor_row  <= n_out.cursor_y;
                r_wheel_total <= n_out.wheel_count;
                r_out_valid   <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
        if (advance && !last_is_final) begin
            case (r_byte_index)
                2'd0:    r_pkt_b0 <= r_in_byte;
                2'd1:    r_pkt_b1 <= r_in_byte;
                default: r_pkt_b2 <= r_in_byte;
            endcase
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OutDataW-$bits(t_result)){1'b0}}, r_out};

    // A completed packet always returns the byte position to the start.
    a_index_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (r_byte_index == 2'd0))
        else $error("byte position not cleared after a packet");

    // Packets are at least three bytes long, so results never load twice in a row.
    a_no_back_to_back_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> !load_out)
        else $error("result register loaded on consecutive cycles");

    // The lower clamp keeps a delivered cursor off zero.
    a_cursor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.cursor_x != '0) && (r_out.cursor_y != '0)))
        else $error("cursor result below one");

    // Three-byte packets carry no extra buttons.
    a_three_byte_buttons: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_four_byte) |-> (!r_out.button_four && !r_out.button_five))
        else $error("extra buttons set in three-byte mode");

    // A stalled finishing byte keeps the input side closed.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && last_is_final && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while finishing byte is stalled");

endmodule

// ----- verif/ps2_mouse_packet_tracker_core_test.sv -----
// Self-checking testbench for the PS/2 mouse packet tracker core.
module ps2_mouse_packet_tracker_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ps2mpt_pkg::*;

    // The limit leaves a wide margin over the slowest correct run.
    localparam int CYCLE_LIMIT = 200000;

    // Result word as it appears on m_axis_tdata, with the top field first.
    typedef struct packed {
        logic [2:0]         pad;
        logic signed [7:0]  wheel;
        logic [6:0]         cur_y;
        logic [6:0]         cur_x;
        logic signed [12:0] dy;
        logic signed [12:0] dx;
        logic               btn5;
        logic               btn4;
        logic               btn_mid;
        logic               btn_right;
        logic               btn_left;
    } t_report;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_wr_en = 1'b0;
    t_cfg_idx     i_cfg_index = CFG_FOUR_BYTE;
    logic [6:0]   i_cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;

    ps2_mouse_packet_tracker_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the configuration registers, updated as they are written.
    logic       cfg_four;
    logic [6:0] cfg_thr;
    logic [3:0] cfg_gain;
    logic [6:0] cfg_xlim;
    logic [6:0] cfg_ylim;

    // Packet assembly and tracking state of the expected behavior.
    logic [1:0] asm_index;
    logic [7:0] asm_bytes [3];
    logic [6:0] col_pos;
    logic [6:0] row_pos;
    logic [7:0] wheel_sum;

    // Bytes waiting to be sent, and the results they are expected to produce.
    logic [7:0] byte_queue [$];
    t_report    expected_reports [$];

    int queued_total = 0;
    int accepted_total = 0;
    int errors = 0;
    int cycle_count = 0;

    // Idle rates in percent for each side, changed by the stimulus between phases.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // A nonzero value asks the receiver to hold off; the value sets the length of the hold-off.
    int stall_cycles_req = 0;
    int stall_left = 0;

    t_report got_report;
    t_report want_report;

    // Gain applies only when the magnitude is strictly above the threshold.
    function automatic int boost(input int d);
        int mag;
        mag = (d < 0) ? -d : d;
        if (mag > int'(cfg_thr)) begin
            d = d * int'(cfg_gain);
        end
        return d;
    endfunction

    // Upper clamp first, then lower, so a limit of zero still leaves the cursor at 1.
    function automatic logic [6:0] limit_pos(input int v, input logic [6:0] lim);
        if (v > int'(lim)) begin
            v = int'(lim);
        end
        if (v < 1) begin
            v = 1;
        end
        return v[6:0];
    endfunction

    // Takes one accepted byte. When it completes a packet, the decoded report
    // goes to the back of expected_reports. A packet completes once the byte
    // position has reached the last slot of the current mode, which also covers
    // a mode change in the middle of a packet.
    task automatic track_byte(input logic [7:0] b);
        logic [1:0] last;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        int         dx;
        int         dy;
        int         dz;
        t_report    r;
        last = cfg_four ? 2'd3 : 2'd2;
        if (asm_index < last) begin
            asm_bytes[asm_index] = b;
            asm_index = asm_index + 2'd1;
            return;
        end
        b0 = asm_bytes[0];
        b1 = asm_bytes[1];
        if (cfg_four) begin
            b2 = asm_bytes[2];
            b3 = b;
        end else begin
            b2 = b;
            b3 = 8'h00;
        end
        asm_index = 2'd0;

        // Nine-bit deltas: the sign bits live in the first byte. Y is inverted
        // so that a positive mouse motion moves up the screen.
        dx = int'(b1) - (b0[4] ? 256 : 0);
        dy = -(int'(b2) - (b0[5] ? 256 : 0));
        dz = int'(b3[2:0]) - (b3[3] ? 8 : 0);
        dx = boost(dx);
        dy = boost(dy);

        col_pos   = limit_pos(int'(col_pos) + dx, cfg_xlim);
        row_pos   = limit_pos(int'(row_pos) + dy, cfg_ylim);
        wheel_sum = wheel_sum + dz[7:0];

        r.pad       = 3'b000;
        r.wheel     = wheel_sum;
        r.cur_y     = row_pos;
        r.cur_x     = col_pos;
        r.dy        = dy[12:0];
        r.dx        = dx[12:0];
        r.btn5      = b3[5];
        r.btn4      = b3[4];
        r.btn_mid   = b0[2];
        r.btn_right = b0[1];
        r.btn_left  = b0[0];
        expected_reports.push_back(r);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Sender. A request stays up until it is taken; a new byte is offered only
    // when the line is free, and the idle rate decides whether to leave a gap.
    // Every taken byte is fed to the predictor at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                track_byte(s_axis_tdata);
                accepted_total++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= byte_queue.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Checks every taken result against the oldest expected report,
    // then decides on ready for the next edge. A long hold-off request keeps
    // ready low for a counted stretch so the core backs up into its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_report = m_axis_tdata;
                if (expected_reports.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_axis_tdata);
                end else begin
                    want_report = expected_reports.pop_front();
                    check_field("left_button", want_report.btn_left, got_report.btn_left);
                    check_field("right_button", want_report.btn_right, got_report.btn_right);
                    check_field("middle_button", want_report.btn_mid, got_report.btn_mid);
                    check_field("button_four", want_report.btn4, got_report.btn4);
                    check_field("button_five", want_report.btn5, got_report.btn5);
                    check_field("move_x", want_report.dx, got_report.dx);
                    check_field("move_y", want_report.dy, got_report.dy);
                    check_field("cursor_x", want_report.cur_x, got_report.cur_x);
                    check_field("cursor_y", want_report.cur_y, got_report.cur_y);
                    check_field("wheel_count", want_report.wheel, got_report.wheel);
                    check_field("zero fill", want_report.pad, got_report.pad);
                end
            end
            if (stall_cycles_req != 0) begin
                stall_left = stall_cycles_req;
                stall_cycles_req = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** ps2_mouse_packet_tracker_core: FAILED **");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        byte_queue.push_back(b);
        queued_total++;
    endtask

    // Waits until every queued byte has been taken and every report has come
    // back, then lets the pipeline empty out behind bytes that did
    // not finish a packet.
    task automatic drain();
        while (accepted_total != queued_total || expected_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // One register write per edge; the enable drops only after the last one.
    task automatic write_reg(input t_cfg_idx idx, input logic [6:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_FOUR_BYTE:  cfg_four = val[0];
            CFG_ACCEL_THR:  cfg_thr  = val;
            CFG_ACCEL_GAIN: cfg_gain = val[3:0];
            CFG_X_LIMIT:    cfg_xlim = val;
            CFG_Y_LIMIT:    cfg_ylim = val;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic four, input logic [6:0] thr,
                                 input logic [3:0] gain, input logic [6:0] xl,
                                 input logic [6:0] yl);
        write_reg(CFG_FOUR_BYTE, {6'd0, four});
        write_reg(CFG_ACCEL_THR, thr);
        write_reg(CFG_ACCEL_GAIN, {3'd0, gain});
        write_reg(CFG_X_LIMIT, xl);
        write_reg(CFG_Y_LIMIT, yl);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Delta choice: fully random over the 9-bit range, right around the
    // acceleration threshold, or a small step.
    function automatic int pick_delta();
        int d;
        case ($urandom_range(0, 2))
            0: d = int'($urandom_range(0, 511)) - 256;
            1: begin
                d = int'(cfg_thr) + int'($urandom_range(0, 2)) - 1;
                if ($urandom_range(0, 1) == 1) begin
                    d = -d;
                end
                if (d > 255) begin
                    d = 255;
                end
            end
            default: d = int'($urandom_range(0, 16)) - 8;
        endcase
        return d;
    endfunction

    // Well-formed packets with random content. In one packet out of ten the
    // sign bits in the first byte are left random, which breaks the pairing
    // between the sign and the delta byte.
    task automatic queue_packets(input int count);
        int         n;
        int         dx;
        int         dy;
        logic [7:0] b0;
        n = 0;
        while (n < count) begin
            dx = pick_delta();
            dy = pick_delta();
            b0 = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 9) != 0) begin
                b0[4] = (dx < 0);
                b0[5] = (dy < 0);
            end
            push_byte(b0);
            push_byte(dx[7:0]);
            push_byte(dy[7:0]);
            if (cfg_four) begin
                push_byte(8'($urandom_range(0, 255)));
            end
            n += cfg_four ? 4 : 3;
        end
    endtask

    initial begin
        // Shadow state starts at the reset values of the core.
        cfg_four  = 1'b0;
        cfg_thr   = RST_ACCEL_THR;
        cfg_gain  = RST_ACCEL_GAIN;
        cfg_xlim  = RST_X_LIMIT;
        cfg_ylim  = RST_Y_LIMIT;
        asm_index = 2'd0;
        asm_bytes[0] = 8'h00;
        asm_bytes[1] = 8'h00;
        asm_bytes[2] = 8'h00;
        col_pos   = 7'd0;
        row_pos   = 7'd0;
        wheel_sum = 8'h00;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 28;
        recv_idle_pct = 45;

        // Directed part, reset configuration, three-byte packets.
        // All zero: no motion, and the first packet lifts the cursor off 0.
        push_byte(8'h00); push_byte(8'h00); push_byte(8'h00);
        // All ones: the three main buttons, X of -1 and Y of +1 after inversion.
        push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFF);
        // Largest negative X and largest positive Y, both accelerated.
        push_byte(8'h30); push_byte(8'h00); push_byte(8'h00);
        // Largest positive X and Y of -128 without sign bits.
        push_byte(8'h0F); push_byte(8'hFF); push_byte(8'h80);
        drain();

        // Wheel packets with the top gain and a zero threshold.
        apply_setting(1'b1, 7'd0, 4'd15, 7'd127, 7'd127);
        push_byte(8'h30); push_byte(8'h00); push_byte(8'h00); push_byte(8'h08);
        push_byte(8'h07); push_byte(8'hFF); push_byte(8'h01); push_byte(8'h37);
        // Three bytes of a wheel packet, then the mode drops to three bytes:
        // the next byte finishes the packet as its Y byte.
        push_byte(8'h01); push_byte(8'h02); push_byte(8'h03);
        drain();
        // Zero gain, a zero column limit and a single-row limit.
        apply_setting(1'b0, 7'd127, 4'd0, 7'd0, 7'd1);
        push_byte(8'h04);
        // Two bytes in three-byte mode, then the mode rises to four bytes.
        push_byte(8'h05); push_byte(8'h06);
        drain();
        apply_setting(1'b1, 7'd127, 4'd15, 7'd127, 7'd127);
        push_byte(8'h07); push_byte(8'h08);
        drain();

        // Random part: several settings, the extremes among them.
        apply_setting(1'b0, 7'd5, 4'd4, 7'd80, 7'd24);
        queue_packets(160);
        drain();

        // The receiver holds off while bytes keep coming, so the core fills
        // up and stops taking requests.
        apply_setting(1'b1, 7'd0, 4'd1, 7'd127, 7'd127);
        stall_cycles_req = 300;
        queue_packets(160);
        drain();

        send_idle_pct = 45;
        recv_idle_pct = 28;
        apply_setting(1'b0, 7'd127, 4'd8, 7'd1, 7'd1);
        queue_packets(80);
        // The sender pauses until every report has come back.
        drain();
        queue_packets(80);
        drain();

        apply_setting(1'b1, 7'd10, 4'd2, 7'd40, 7'd100);
        queue_packets(160);
        drain();

        // No idling on either side from here on.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (2) begin
            apply_setting(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                          4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)),
                          7'($urandom_range(0, 127)));
            queue_packets(160);
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("** ps2_mouse_packet_tracker_core: PASSED **");
        end else begin
            $display("** ps2_mouse_packet_tracker_core: FAILED **");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ps2mpt_pkg.sv
rtl/ps2_mouse_packet_tracker_core.sv
verif/ps2_mouse_packet_tracker_core_test.sv
